[rtl/swtsd_pkg.sv]
// Shared types, constants and functions of the scratchpad temperature decoder.
package swtsd_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [3:0] cnt_t;
  typedef logic [3:0] pos_t;

  typedef enum logic [1:0] {
    ACT_PRESENCE_FAIL = 2'd0,
    ACT_SCRATCH_BYTE  = 2'd1,
    ACT_DISCOVER      = 2'd2
  } act_e;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] channel;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          channel_out;
    logic signed [15:0]  temperature;
    logic                temp_valid;
    logic                crc_error;
    logic                presence_error;
    cnt_t                error_total;
  } out_item_t;

  localparam cnt_t SAT_LIMIT       = 4'd10;
  localparam cnt_t MIN_GOOD_RESET  = 4'd3;

  localparam pos_t POS_TEMP_LSB    = 4'd0;
  localparam pos_t POS_TEMP_MSB    = 4'd1;
  localparam pos_t POS_CONFIG      = 4'd4;
  localparam pos_t POS_COUNT_REM   = 4'd6;
  localparam pos_t POS_COUNT_PER_C = 4'd7;
  localparam pos_t POS_CRC         = 4'd8;

  localparam logic [7:0] FAM_COARSE   = 8'h10;
  localparam logic [7:0] FAM_NATIVE_A = 8'h28;
  localparam logic [7:0] FAM_NATIVE_B = 8'h22;

  localparam logic [7:0]  CRC_POLY       = 8'h8C;
  localparam logic [7:0]  COUNT_PER_C_NOM = 8'h10;
  localparam logic [15:0] COARSE_MASK    = 16'hFFF0;
  localparam logic [15:0] COUNT_BIAS     = 16'd12;

  localparam logic [1:0] RES_9_BIT  = 2'b00;
  localparam logic [1:0] RES_10_BIT = 2'b01;
  localparam logic [1:0] RES_11_BIT = 2'b10;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic cnt_t sat_inc(input cnt_t c);
    return (c < SAT_LIMIT) ? c + 4'd1 : SAT_LIMIT;
  endfunction

endpackage

[rtl/single_wire_temp_scratchpad_decoder_top.sv]
// Top level of the scratchpad temperature decoder: handshakes, input and result registers.
// An item is registered on acceptance; its result is registered as it leaves the input
// register. One item is accepted every cycle while results are taken; the per-channel state
// update and the decode are combinational between input register and result register.
// Reset clears channel state and counters, not stored bytes; sets good-read threshold to 3.
module single_wire_temp_scratchpad_decoder_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  swtsd_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output swtsd_pkg::out_item_t out_item_o,
  input  logic                 cfg_we_i,
  input  swtsd_pkg::cnt_t      cfg_wdata_i
);
  import swtsd_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  cnt_t      min_good_q;

  logic      has_result;
  out_item_t result;
  logic      out_free;
  logic      s1_go;
  logic      in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!has_result || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  swtsd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (s1_go),
    .item_i       (s1_item_q),
    .min_good_i   (min_good_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      min_good_q  <= MIN_GOOD_RESET;
    end else begin
      if (cfg_we_i) begin
        min_good_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go && has_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
    if (s1_go && has_result) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input stage");

  a_presence_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.presence_error) |->
      (!out_item_q.temp_valid && !out_item_q.crc_error && out_item_q.temperature == 16'sd0))
    else $error("presence failure item carries a reading or CRC flag");

  a_crc_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.crc_error) |->
      (!out_item_q.temp_valid && out_item_q.error_total != 4'd0))
    else $error("CRC error item marked valid or with zero error count");

  a_valid_no_errors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.temp_valid) |-> (out_item_q.error_total == 4'd0))
    else $error("valid reading reported with a nonzero error count");

  a_err_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.error_total <= SAT_LIMIT))
    else $error("error count beyond its saturation limit");

endmodule

[rtl/swtsd_decode.sv]
// Conversion of stored scratchpad bytes into a reading in sixteenths of a degree.
module swtsd_decode (
  input  logic               coarse_i,
  input  logic [7:0]         temp_lsb_i,
  input  logic [7:0]         temp_msb_i,
  input  logic [1:0]         res_cfg_i,
  input  logic [7:0]         count_rem_i,
  input  logic [7:0]         count_per_c_i,
  output logic signed [15:0] temperature_o
);
  import swtsd_pkg::*;

  logic [15:0] raw;
  logic [15:0] shifted;
  logic [15:0] result;

  always_comb begin
    raw     = {temp_msb_i, temp_lsb_i};
    shifted = raw << 3;
    result  = raw;
    if (coarse_i) begin
      result = shifted;
      if (count_per_c_i == COUNT_PER_C_NOM) begin
        result = (shifted & COARSE_MASK) + COUNT_BIAS - {8'h00, count_rem_i};
      end
    end else begin
      unique case (res_cfg_i)
        RES_9_BIT:  result = raw & 16'hFFF8;
        RES_10_BIT: result = raw & 16'hFFFC;
        RES_11_BIT: result = raw & 16'hFFFE;
        default:    result = raw;
      endcase
    end
    temperature_o = signed'(result);
  end

endmodule

[rtl/swtsd_core.sv]
// Per-channel state, CRC check, counters and result formation for one item.
module swtsd_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  swtsd_pkg::in_item_t   item_i,
  input  swtsd_pkg::cnt_t       min_good_i,
  output logic                  has_result_o,
  output swtsd_pkg::out_item_t  result_o
);
  import swtsd_pkg::*;

  pos_t       pos_q   [CHANNELS];
  logic [7:0] crc_q   [CHANNELS];
  cnt_t       good_q  [CHANNELS];
  cnt_t       err_q   [CHANNELS];
  logic       en_q    [CHANNELS];
  logic       coarse_q[CHANNELS];

  logic [7:0] lsb_q   [CHANNELS];
  logic [7:0] msb_q   [CHANNELS];
  logic [1:0] cfg_q   [CHANNELS];
  logic [7:0] rem_q   [CHANNELS];
  logic [7:0] perc_q  [CHANNELS];

  logic [CH_IDX_W-1:0] ch_idx;
  logic                ch_ok;
  pos_t                cur_pos;
  pos_t                pos_d;
  logic [7:0]          crc_d;
  cnt_t                good_d;
  cnt_t                err_d;
  logic                en_d;
  logic                coarse_d;
  logic                upd;
  logic                wr_byte;
  logic signed [15:0]  dec_temp;

  assign ch_idx = item_i.channel[CH_IDX_W-1:0];
  assign ch_ok  = 32'(item_i.channel) < CHANNELS;

  swtsd_decode u_decode (
    .coarse_i      (coarse_q[ch_idx]),
    .temp_lsb_i    (lsb_q[ch_idx]),
    .temp_msb_i    (msb_q[ch_idx]),
    .res_cfg_i     (cfg_q[ch_idx]),
    .count_rem_i   (rem_q[ch_idx]),
    .count_per_c_i (perc_q[ch_idx]),
    .temperature_o (dec_temp)
  );

  always_comb begin
    cur_pos = pos_q[ch_idx];
    if (cur_pos > POS_CRC) begin
      cur_pos = '0;
    end
    pos_d        = cur_pos;
    crc_d        = crc_q[ch_idx];
    good_d       = good_q[ch_idx];
    err_d        = err_q[ch_idx];
    en_d         = en_q[ch_idx];
    coarse_d     = coarse_q[ch_idx];
    upd          = 1'b0;
    wr_byte      = 1'b0;
    has_result_o = 1'b0;
    result_o     = '0;
    result_o.channel_out = item_i.channel;
    if (ch_ok) begin
      unique case (act_e'(item_i.action))
        ACT_PRESENCE_FAIL: begin
          upd          = 1'b1;
          en_d         = 1'b0;
          err_d        = sat_inc(err_q[ch_idx]);
          good_d       = '0;
          pos_d        = '0;
          crc_d        = '0;
          has_result_o = 1'b1;
          result_o.presence_error = 1'b1;
          result_o.error_total    = err_d;
        end
        ACT_DISCOVER: begin
          upd    = 1'b1;
          good_d = '0;
          pos_d  = '0;
          crc_d  = '0;
          if (item_i.data_byte == FAM_COARSE || item_i.data_byte == FAM_NATIVE_A ||
              item_i.data_byte == FAM_NATIVE_B) begin
            coarse_d = (item_i.data_byte == FAM_COARSE);
            en_d     = 1'b1;
            err_d    = '0;
          end else begin
            en_d = 1'b0;
          end
        end
        ACT_SCRATCH_BYTE: begin
          upd     = 1'b1;
          wr_byte = 1'b1;
          if (cur_pos != POS_CRC) begin
            crc_d = crc_update(crc_q[ch_idx], item_i.data_byte);
            pos_d = cur_pos + 4'd1;
          end else begin
            pos_d        = '0;
            crc_d        = '0;
            has_result_o = 1'b1;
            if (crc_q[ch_idx] != item_i.data_byte) begin
              good_d = '0;
              err_d  = sat_inc(err_q[ch_idx]);
              result_o.crc_error = 1'b1;
            end else begin
              good_d = sat_inc(good_q[ch_idx]);
              err_d  = '0;
              result_o.temperature = dec_temp;
              result_o.temp_valid  = en_q[ch_idx] && (good_d >= min_good_i);
            end
            result_o.error_total = err_d;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i]    <= '0;
        crc_q[i]    <= '0;
        good_q[i]   <= '0;
        err_q[i]    <= '0;
        en_q[i]     <= 1'b0;
        coarse_q[i] <= 1'b0;
      end
    end else if (go_i && upd) begin
      pos_q[ch_idx]    <= pos_d;
      crc_q[ch_idx]    <= crc_d;
      good_q[ch_idx]   <= good_d;
      err_q[ch_idx]    <= err_d;
      en_q[ch_idx]     <= en_d;
      coarse_q[ch_idx] <= coarse_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i && wr_byte) begin
      unique case (cur_pos)
        POS_TEMP_LSB:    lsb_q[ch_idx]  <= item_i.data_byte;
        POS_TEMP_MSB:    msb_q[ch_idx]  <= item_i.data_byte;
        POS_CONFIG:      cfg_q[ch_idx]  <= item_i.data_byte[6:5];
        POS_COUNT_REM:   rem_q[ch_idx]  <= item_i.data_byte;
        POS_COUNT_PER_C: perc_q[ch_idx] <= item_i.data_byte;
        default: begin
        end
      endcase
    end
  end

endmodule

[tb/single_wire_temp_scratchpad_decoder_top_tb.sv]
// Self-checking testbench that drives bus events into the scratchpad decoder and checks every reading.
module single_wire_temp_scratchpad_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swtsd_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 6;
  localparam int HOLD_PHASE = 4;
  localparam int EVENTS_PER_PHASE = 30;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  cnt_t      cfg_wdata = '0;

  logic hold_rx = 1'b0;
  logic hold_go = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  in_item_t  bus_events[$];
  in_item_t  lanes[CHANNELS][$];
  out_item_t expected_reports[$];

  logic [3:0] pad_pos[CHANNELS] = '{default: '0};
  logic [7:0] pad_bytes[CHANNELS][9] = '{default: '0};
  logic [7:0] pad_crc[CHANNELS] = '{default: '0};
  cnt_t       good_reads[CHANNELS] = '{default: '0};
  cnt_t       fault_run[CHANNELS] = '{default: '0};
  logic       ch_enabled[CHANNELS] = '{default: 1'b0};
  logic       ch_coarse[CHANNELS] = '{default: 1'b0};
  cnt_t       valid_threshold = MIN_GOOD_RESET;

  int failures = 0;
  int events_taken = 0;
  int reports_checked = 0;
  int valid_seen = 0;
  int crc_faults_seen = 0;
  int presence_seen = 0;
  int settings_used = 1;
  int unsigned cycle_count = 0;

  always #2 clk = ~clk;

  single_wire_temp_scratchpad_decoder_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ 8'h8C;
      end
    end
    return c;
  endfunction

  function automatic cnt_t sat_bump(input cnt_t c);
    return (c < SAT_LIMIT) ? cnt_t'(c + 4'd1) : SAT_LIMIT;
  endfunction

  function automatic void apply_bus_event(input in_item_t ev);
    out_item_t   rep;
    int          ch;
    int          pos;
    logic [15:0] raw;
    ch = int'(ev.channel);
    rep = '0;
    rep.channel_out = ev.channel;
    case (ev.action)
      ACT_PRESENCE_FAIL: begin
        ch_enabled[ch] = 1'b0;
        fault_run[ch] = sat_bump(fault_run[ch]);
        good_reads[ch] = '0;
        pad_pos[ch] = '0;
        pad_crc[ch] = '0;
        rep.presence_error = 1'b1;
        rep.error_total = fault_run[ch];
        expected_reports.push_back(rep);
      end
      ACT_DISCOVER: begin
        good_reads[ch] = '0;
        pad_pos[ch] = '0;
        pad_crc[ch] = '0;
        if (ev.data_byte == FAM_COARSE || ev.data_byte == FAM_NATIVE_A ||
            ev.data_byte == FAM_NATIVE_B) begin
          ch_coarse[ch] = (ev.data_byte == FAM_COARSE);
          ch_enabled[ch] = 1'b1;
          fault_run[ch] = '0;
        end else begin
          ch_enabled[ch] = 1'b0;
        end
      end
      ACT_SCRATCH_BYTE: begin
        pos = (pad_pos[ch] > POS_CRC) ? 0 : int'(pad_pos[ch]);
        pad_bytes[ch][pos] = ev.data_byte;
        if (pos < POS_CRC) begin
          pad_crc[ch] = crc8_step(pad_crc[ch], ev.data_byte);
          pad_pos[ch] = 4'(pos + 1);
        end else begin
          pad_pos[ch] = '0;
          if (pad_crc[ch] != ev.data_byte) begin
            good_reads[ch] = '0;
            fault_run[ch] = sat_bump(fault_run[ch]);
            rep.crc_error = 1'b1;
          end else begin
            good_reads[ch] = sat_bump(good_reads[ch]);
            fault_run[ch] = '0;
            raw = {pad_bytes[ch][POS_TEMP_MSB], pad_bytes[ch][POS_TEMP_LSB]};
            if (ch_coarse[ch]) begin
              raw = raw << 3;
              if (pad_bytes[ch][POS_COUNT_PER_C] == 8'h10) begin
                raw = (raw & 16'hFFF0) + 16'd12 - {8'h00, pad_bytes[ch][POS_COUNT_REM]};
              end
            end else begin
              case (pad_bytes[ch][POS_CONFIG][6:5])
                RES_9_BIT:  raw = raw & 16'hFFF8;
                RES_10_BIT: raw = raw & 16'hFFFC;
                RES_11_BIT: raw = raw & 16'hFFFE;
                default:    raw = raw;
              endcase
            end
            rep.temperature = raw;
            rep.temp_valid = ch_enabled[ch] && (good_reads[ch] >= valid_threshold);
          end
          pad_crc[ch] = '0;
          rep.error_total = fault_run[ch];
          expected_reports.push_back(rep);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_report(input out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      $error("unexpected result on channel %0d", got.channel_out);
      failures++;
      return;
    end
    want = expected_reports.pop_front();
    reports_checked++;
    if (got.temp_valid === 1'b1) valid_seen++;
    if (got.crc_error === 1'b1) crc_faults_seen++;
    if (got.presence_error === 1'b1) presence_seen++;
    if (got.channel_out !== want.channel_out) begin
      $error("channel_out: expected %0d, got %0d", want.channel_out, got.channel_out);
      failures++;
    end
    if (got.temperature !== want.temperature) begin
      $error("temperature: expected %0d, got %0d", want.temperature, got.temperature);
      failures++;
    end
    if (got.temp_valid !== want.temp_valid) begin
      $error("temp_valid: expected %0d, got %0d", want.temp_valid, got.temp_valid);
      failures++;
    end
    if (got.crc_error !== want.crc_error) begin
      $error("crc_error: expected %0d, got %0d", want.crc_error, got.crc_error);
      failures++;
    end
    if (got.presence_error !== want.presence_error) begin
      $error("presence_error: expected %0d, got %0d", want.presence_error,
             got.presence_error);
      failures++;
    end
    if (got.error_total !== want.error_total) begin
      $error("error_total: expected %0d, got %0d", want.error_total, got.error_total);
      failures++;
    end
  endfunction

  function automatic void add_event(input int ch, input logic [1:0] act, input logic [7:0] b);
    in_item_t ev;
    ev.action = act;
    ev.channel = 2'(ch);
    ev.data_byte = b;
    lanes[ch].push_back(ev);
  endfunction

  function automatic void add_scratchpad(input int ch, input logic [7:0] body[8],
                                         input bit good_crc);
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < 8; i++) begin
      add_event(ch, ACT_SCRATCH_BYTE, body[i]);
      crc = crc8_step(crc, body[i]);
    end
    if (!good_crc) begin
      crc = crc ^ (8'h01 << $urandom_range(7));
    end
    add_event(ch, ACT_SCRATCH_BYTE, crc);
  endfunction

  function automatic void random_body(output logic [7:0] body[8]);
    for (int i = 0; i < 8; i++) begin
      body[i] = 8'($urandom);
    end
    if ($urandom_range(1) == 1) begin
      body[POS_COUNT_PER_C] = COUNT_PER_C_NOM;
    end
  endfunction

  function automatic logic [7:0] random_family();
    int r;
    r = $urandom_range(9);
    if (r < 3) return FAM_COARSE;
    if (r < 6) return FAM_NATIVE_A;
    if (r < 8) return FAM_NATIVE_B;
    return 8'($urandom);
  endfunction

  function automatic void flush_lanes();
    int ch;
    bit busy;
    busy = 1'b1;
    while (busy) begin
      busy = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        if (lanes[c].size() != 0) busy = 1'b1;
      end
      if (busy) begin
        ch = $urandom_range(CHANNELS - 1);
        if (lanes[ch].size() != 0) begin
          bus_events.push_back(lanes[ch].pop_front());
        end
      end
    end
  endfunction

  function automatic void build_burst(input int n);
    logic [7:0] body[8];
    int         ch;
    int         r;
    int         k;
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(CHANNELS - 1);
      r = $urandom_range(99);
      if (r < 6) begin
        add_event(ch, ACT_PRESENCE_FAIL, 8'($urandom));
      end else if (r < 14) begin
        add_event(ch, ACT_DISCOVER, random_family());
      end else if (r < 17) begin
        add_event(ch, ACT_UNUSED, 8'($urandom));
      end else if (r < 21) begin
        random_body(body);
        k = $urandom_range(1, 8);
        for (int j = 0; j < k; j++) begin
          add_event(ch, ACT_SCRATCH_BYTE, body[j]);
        end
        add_event(ch, ACT_DISCOVER, random_family());
      end else begin
        random_body(body);
        add_scratchpad(ch, body, $urandom_range(99) < 88);
      end
    end
    flush_lanes();
  endfunction

  task automatic wait_idle();
    while (bus_events.size() != 0 || in_valid || expected_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input cnt_t v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    valid_threshold = v;
    settings_used++;
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_bus_event(in_item);
        events_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (bus_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= bus_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_report(out_item);
      end
      out_stall <= hold_rx || ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [7:0] body[8];
    cnt_t       thr_tab[PHASES];
    int         send_tab[PHASES];
    int         recv_tab[PHASES];
    thr_tab = '{MIN_GOOD_RESET, 4'd0, 4'd15, 4'd10, 4'd1, 4'd5};
    send_tab = '{0, 58, 0, 6, 0, 58};
    recv_tab = '{0, 0, 58, 6, 0, 58};
    thr_tab[PHASES - 1] = cnt_t'($urandom_range(2, 9));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_event(0, ACT_PRESENCE_FAIL, 8'hFF);
    add_event(1, ACT_UNUSED, 8'hFF);
    add_event(1, ACT_DISCOVER, FAM_COARSE);
    body = '{8'hFF, 8'h7F, 8'h00, 8'hFF, 8'h60, 8'hFF, 8'hFF, COUNT_PER_C_NOM};
    add_scratchpad(1, body, 1'b1);
    add_event(2, ACT_DISCOVER, 8'h77);
    body = '{8'h00, 8'h80, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h0C, 8'h00};
    add_scratchpad(2, body, 1'b0);
    add_event(3, ACT_DISCOVER, FAM_NATIVE_B);
    add_event(3, ACT_PRESENCE_FAIL, 8'h00);
    flush_lanes();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        set_threshold(thr_tab[p]);
      end
      send_idle_pct = send_tab[p];
      recv_stall_pct = recv_tab[p];
      if (p == HOLD_PHASE) begin
        hold_go = 1'b1;
      end
      build_burst(EVENTS_PER_PHASE);
    end
    wait_idle();

    $display("Accepted %0d bus events and checked %0d results under %0d threshold settings.",
             events_taken, reports_checked, settings_used);
    $display("Results held %0d valid readings, %0d CRC faults and %0d presence faults.",
             valid_seen, crc_faults_seen, presence_seen);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/swtsd_pkg.sv
rtl/swtsd_decode.sv
rtl/swtsd_core.sv
rtl/single_wire_temp_scratchpad_decoder_top.sv
tb/single_wire_temp_scratchpad_decoder_top_tb.sv
